[rtl/core/top_k_sorted_insert_table_defines.svh]
// assertion macros for the sorted insert table
// used by the top level only; no other dependencies
`ifndef TOP_K_SORTED_INSERT_TABLE_DEFINES_SVH
`define TOP_K_SORTED_INSERT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define TKSI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while in reset
`define TKSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TKSI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TKSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/tksi_pkg.sv]
// shared types and codes for the sorted insert table
// no dependencies
package tksi_pkg;

	// transaction kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// one table entry
	typedef struct packed {
		logic [31:0] points;
		logic [15:0] lines;
		logic [7:0]  level;
		logic [6:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [15:0] tag;
	} entry_t;

	// control that travels with the wavefront
	typedef struct packed {
		logic       is_read;
		logic [3:0] idx;
		logic       landed;
	} wave_ctl_t;

endpackage

[rtl/core/tksi_cell.sv]
// one cell of the sorted table: holds one entry and passes a carry down
// depends on tksi_pkg
module tksi_cell #(
	parameter int CELL_INDEX = 0,
	parameter int PW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_in,
	input  tksi_pkg::wave_ctl_t ctl_in,
	input  logic [PW-1:0]     pos_in,
	input  tksi_pkg::entry_t  ent_in,
	output logic              tok_q,
	output tksi_pkg::wave_ctl_t ctl_q,
	output logic [PW-1:0]     pos_q,
	output tksi_pkg::entry_t  ent_q,
	output tksi_pkg::entry_t  held_q
);
	import tksi_pkg::*;

	logic swap;
	logic hit_read;
	logic landed_next;

	// insert lands here when the stored points are not above the carry
	assign swap = !ctl_in.is_read && (held_q.points <= ent_in.points);
	assign hit_read = ctl_in.is_read && ({28'd0, ctl_in.idx} == 32'(CELL_INDEX));
	assign landed_next = ctl_in.landed | swap;

	// token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// stored entry, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (tok_in && swap) begin
			held_q <= ent_in;
		end
	end

	// carry handed to the next cell
	always_ff @(posedge clk) begin
		if (tok_in) begin
			ctl_q.is_read <= ctl_in.is_read;
			ctl_q.idx     <= ctl_in.idx;
			ctl_q.landed  <= landed_next;
			pos_q         <= landed_next ? pos_in : pos_in + PW'(1);
			if (swap || hit_read) begin
				ent_q <= held_q;
			end else begin
				ent_q <= ent_in;
			end
		end
	end

endmodule

[rtl/core/top_k_sorted_insert_table.sv]
// Sorted best-entries table built as a chain of TABLE_DEPTH cells.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. kind selects insert or read; the other inputs carry the new
// entry or the read index.
// Result channel: done is high for exactly one cycle with the result on the
// output ports; the receiver takes it in that cycle and cannot stall it.
// Each command launches a wavefront that visits one cell per clock, so a
// result appears once the wavefront has left the last cell, and busy
// stays high until then; a new command can be taken in the done cycle, so
// a new transaction is taken only after the previous one has finished.
// The pace is set by the token walking the cell chain.
// An insert lands above all older entries of equal points; lower entries move
// down one place and the last one drops. Inserts below the lowest stored
// points are refused and leave the table as it was.
// Reset clears every entry to zero points, so the first inserts always land.
`include "top_k_sorted_insert_table_defines.svh"
module top_k_sorted_insert_table #(
	parameter int TABLE_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] new_points,
	input  logic [15:0] new_lines,
	input  logic [7:0]  new_level,
	input  logic [6:0]  new_hours,
	input  logic [5:0]  new_minutes,
	input  logic [5:0]  new_seconds,
	input  logic [15:0] player_tag,
	input  logic [3:0]  read_index,
	output logic        done,
	output logic        accepted,
	output logic [3:0]  position,
	output logic [31:0] entry_points,
	output logic [15:0] entry_lines,
	output logic [7:0]  entry_level,
	output logic [6:0]  entry_hours,
	output logic [5:0]  entry_minutes,
	output logic [5:0]  entry_seconds,
	output logic [15:0] entry_tag,
	output logic [31:0] best_points,
	output logic [31:0] worst_points
);
	import tksi_pkg::*;

	localparam int PW = $clog2(TABLE_DEPTH + 1);

	logic              take;
	logic              busy_q;
	logic              done_q;
	wave_ctl_t         head_ctl;
	entry_t            head_ent;
	logic [TABLE_DEPTH-1:0] tok;
	wave_ctl_t         ctl  [TABLE_DEPTH];
	logic [PW-1:0]     pos  [TABLE_DEPTH];
	entry_t            ent  [TABLE_DEPTH];
	entry_t            held [TABLE_DEPTH];
	logic [TABLE_DEPTH-2:0] order_ok;

	wave_ctl_t         last_ctl;
	logic [PW-1:0]     last_pos;
	entry_t            last_ent;

	logic        accepted_q;
	logic [3:0]  position_q;
	entry_t      entry_q;
	logic [31:0] best_q;
	logic [31:0] worst_q;

	// command handshake
	assign take = start && !busy_q;
	assign busy = busy_q;

	// wavefront head built from the command
	assign head_ctl.is_read = (kind == KIND_READ);
	assign head_ctl.idx     = read_index;
	assign head_ctl.landed  = 1'b0;
	always_comb begin
		head_ent = '0;
		if (kind == KIND_INSERT) begin
			head_ent.points  = new_points;
			head_ent.lines   = new_lines;
			head_ent.level   = new_level;
			head_ent.hours   = new_hours;
			head_ent.minutes = new_minutes;
			head_ent.seconds = new_seconds;
			head_ent.tag     = player_tag;
		end
	end

	// cell chain
	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				tksi_cell #(.CELL_INDEX(gi), .PW(PW)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.tok_in (take),
					.ctl_in (head_ctl),
					.pos_in ('0),
					.ent_in (head_ent),
					.tok_q  (tok[gi]),
					.ctl_q  (ctl[gi]),
					.pos_q  (pos[gi]),
					.ent_q  (ent[gi]),
					.held_q (held[gi])
				);
			end else begin : g_body
				tksi_cell #(.CELL_INDEX(gi), .PW(PW)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.tok_in (tok[gi-1]),
					.ctl_in (ctl[gi-1]),
					.pos_in (pos[gi-1]),
					.ent_in (ent[gi-1]),
					.tok_q  (tok[gi]),
					.ctl_q  (ctl[gi]),
					.pos_q  (pos[gi]),
					.ent_q  (ent[gi]),
					.held_q (held[gi])
				);
			end
		end
		for (gi = 0; gi < TABLE_DEPTH - 1; gi++) begin : g_order
			assign order_ok[gi] = held[gi].points >= held[gi+1].points;
		end
	endgenerate

	assign last_ctl = ctl[TABLE_DEPTH-1];
	assign last_pos = pos[TABLE_DEPTH-1];
	assign last_ent = ent[TABLE_DEPTH-1];

	// busy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tok[TABLE_DEPTH-1];
			if (take) begin
				busy_q <= 1'b1;
			end else if (tok[TABLE_DEPTH-1]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result capture once the wavefront leaves the last cell
	always_ff @(posedge clk) begin
		if (tok[TABLE_DEPTH-1]) begin
			accepted_q <= !last_ctl.is_read && last_ctl.landed;
			if (last_ctl.is_read) begin
				position_q <= last_ctl.idx;
				entry_q    <= last_ent;
			end else begin
				position_q <= last_ctl.landed ? 4'(last_pos) : 4'd0;
				entry_q    <= '0;
			end
			best_q  <= held[0].points;
			worst_q <= held[TABLE_DEPTH-1].points;
		end
	end

	assign done          = done_q;
	assign accepted      = accepted_q;
	assign position      = position_q;
	assign entry_points  = entry_q.points;
	assign entry_lines   = entry_q.lines;
	assign entry_level   = entry_q.level;
	assign entry_hours   = entry_q.hours;
	assign entry_minutes = entry_q.minutes;
	assign entry_seconds = entry_q.seconds;
	assign entry_tag     = entry_q.tag;
	assign best_points   = best_q;
	assign worst_points  = worst_q;

	// checks on the chain and the handshake
	`TKSI_ASSERT_IMPL(a_one_wave, clk, arst_n, 1'b1, $onehot0(tok), "more than one wavefront")
	`TKSI_ASSERT_IMPL(a_sorted, clk, arst_n, 1'b1, &order_ok, "table lost descending order")
	`TKSI_ASSERT_NEXT(a_take_busy, clk, arst_n, take, busy_q, "busy not raised after command")
	`TKSI_ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, !busy_q && (tok == '0), "done while busy")

endmodule

[bench/tb_top_k_sorted_insert_table.sv]
// self-checking bench for the sorted best-entries table: directed and random commands
// checked against a cycle-free ranking predictor; depends on tksi_pkg and the top level
`timescale 1ns / 1ps

module tb_top_k_sorted_insert_table;
	import tksi_pkg::*;

	localparam int DEPTH      = 10;
	localparam int N_RANDOM   = 1830;
	localparam int QUIET_TAIL = 180;

	// one command as the sender holds it
	typedef struct {
		logic       kind;
		entry_t     e;
		logic [3:0] ridx;
		bit         drain_first;
	} cmd_t;

	// one result as the block should report it
	typedef struct {
		logic        accepted;
		logic [3:0]  position;
		entry_t      e;
		logic [31:0] best;
		logic [31:0] worst;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = KIND_INSERT;
	logic [31:0] new_points = '0;
	logic [15:0] new_lines = '0;
	logic [7:0]  new_level = '0;
	logic [6:0]  new_hours = '0;
	logic [5:0]  new_minutes = '0;
	logic [5:0]  new_seconds = '0;
	logic [15:0] player_tag = '0;
	logic [3:0]  read_index = '0;
	logic        busy, done, accepted;
	logic [3:0]  position;
	logic [31:0] entry_points, best_points, worst_points;
	logic [15:0] entry_lines, entry_tag;
	logic [7:0]  entry_level;
	logic [6:0]  entry_hours;
	logic [5:0]  entry_minutes, entry_seconds;

	cmd_t    cmd_backlog[$];
	result_t due_results[$];
	entry_t  ranking[DEPTH];
	cmd_t    cur;
	bit      have_cur = 0;
	int      idle_left = 0;
	int      mismatch_count = 0;
	int      n_landed = 0, n_refused = 0, n_reads = 0;
	logic [DEPTH-1:0] landed_at = '0;
	result_t got, want;

	top_k_sorted_insert_table #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.new_points(new_points), .new_lines(new_lines), .new_level(new_level),
		.new_hours(new_hours), .new_minutes(new_minutes), .new_seconds(new_seconds),
		.player_tag(player_tag), .read_index(read_index), .done(done),
		.accepted(accepted), .position(position), .entry_points(entry_points),
		.entry_lines(entry_lines), .entry_level(entry_level), .entry_hours(entry_hours),
		.entry_minutes(entry_minutes), .entry_seconds(entry_seconds),
		.entry_tag(entry_tag), .best_points(best_points), .worst_points(worst_points)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] g, input logic [31:0] w);
		if (g !== w)
			report_mismatch($sformatf("%s got %0h expected %0h", name, g, w));
	endtask

	// apply one command to the ranking and return what the block should report
	function automatic result_t rank_and_store(input cmd_t c);
		result_t r;
		int      pos;
		r = '{default: '0};
		if (c.kind == KIND_INSERT) begin
			if (c.e.points >= ranking[DEPTH-1].points) begin
				pos = 0;
				for (int i = 0; i < DEPTH; i++)
					if (ranking[i].points > c.e.points)
						pos++;
				if (pos > DEPTH - 1)
					pos = DEPTH - 1;
				for (int i = DEPTH - 1; i > pos; i--)
					ranking[i] = ranking[i-1];
				ranking[pos] = c.e;
				r.accepted = 1'b1;
				r.position = pos[3:0];
				n_landed++;
				landed_at[pos] = 1'b1;
			end else begin
				n_refused++;
			end
		end else begin
			r.position = c.ridx;
			if (c.ridx < DEPTH)
				r.e = ranking[c.ridx];
			n_reads++;
		end
		r.best  = ranking[0].points;
		r.worst = ranking[DEPTH-1].points;
		return r;
	endfunction

	task automatic add_insert(input logic [31:0] pts, input logic [15:0] lines,
			input logic [7:0] level, input logic [6:0] h, input logic [5:0] m,
			input logic [5:0] s, input logic [15:0] tag, input bit drain);
		cmd_t c;
		c.kind = KIND_INSERT;
		c.e = '{pts, lines, level, h, m, s, tag};
		c.ridx = 4'($urandom);
		c.drain_first = drain;
		cmd_backlog.push_back(c);
	endtask

	task automatic add_read(input logic [3:0] idx);
		cmd_t c;
		c.kind = KIND_READ;
		c.e = entry_t'({$urandom, $urandom, $urandom, $urandom});
		c.ridx = idx;
		c.drain_first = 0;
		cmd_backlog.push_back(c);
	endtask

	// sender: takes transactions from the backlog, idles in short bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				due_results.push_back(rank_and_store(cur));
				have_cur = 0;
			end
			if (!have_cur && cmd_backlog.size() > 0 &&
					!(cmd_backlog[0].drain_first && due_results.size() != 0)) begin
				cur = cmd_backlog.pop_front();
				have_cur = 1;
			end
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (have_cur && cmd_backlog.size() > QUIET_TAIL &&
					((cmd_backlog.size() / 200) % 2 == 0) && $urandom_range(0, 9) == 0) begin
				idle_left = $urandom_range(0, 3);
				start <= 1'b0;
			end else if (have_cur) begin
				start       <= 1'b1;
				kind        <= cur.kind;
				new_points  <= cur.e.points;
				new_lines   <= cur.e.lines;
				new_level   <= cur.e.level;
				new_hours   <= cur.e.hours;
				new_minutes <= cur.e.minutes;
				new_seconds <= cur.e.seconds;
				player_tag  <= cur.e.tag;
				read_index  <= cur.ridx;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// receiver: every strobed result is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			got = '{accepted, position,
				'{entry_points, entry_lines, entry_level, entry_hours,
				entry_minutes, entry_seconds, entry_tag},
				best_points, worst_points};
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = due_results.pop_front();
				compare_field("accepted", got.accepted, want.accepted);
				compare_field("position", got.position, want.position);
				compare_field("entry_points", got.e.points, want.e.points);
				compare_field("entry_lines", got.e.lines, want.e.lines);
				compare_field("entry_level", got.e.level, want.e.level);
				compare_field("entry_hours", got.e.hours, want.e.hours);
				compare_field("entry_minutes", got.e.minutes, want.e.minutes);
				compare_field("entry_seconds", got.e.seconds, want.e.seconds);
				compare_field("entry_tag", got.e.tag, want.e.tag);
				compare_field("best_points", got.best, want.best);
				compare_field("worst_points", got.worst, want.worst);
			end
		end
	end

	// stimulus and end of run
	initial begin
		longint      base;
		logic [31:0] recent[8];
		logic [31:0] pts;
		int          sel;
		for (int i = 0; i < DEPTH; i++)
			ranking[i] = '0;
		for (int i = 0; i < 8; i++)
			recent[i] = '0;

		// directed: empty table, extremes, ties at top and bottom, refusals
		add_read(4'd0);
		add_insert(32'd0, 16'd0, 8'd0, 7'd0, 6'd0, 6'd0, 16'd0, 0);
		add_insert(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 7'h7F, 6'h3F, 6'h3F, 16'hFFFF, 0);
		add_insert(32'hFFFF_FFFF, 16'h1234, 8'h5A, 7'd99, 6'd59, 6'd59, 16'hA5A5, 0);
		for (int i = 0; i < 8; i++)
			add_insert(32'(1000 - 100 * i), 16'(i), 8'(i), 7'(i), 6'(i), 6'(i), 16'(i), 0);
		add_insert(32'd0, 16'd1, 8'd1, 7'd1, 6'd1, 6'd1, 16'd1, 0);
		add_insert(32'd300, 16'hBEEF, 8'h77, 7'd50, 6'd30, 6'd15, 16'h0300, 0);
		add_insert(32'd299, 16'd2, 8'd2, 7'd2, 6'd2, 6'd2, 16'd2, 0);
		add_insert(32'd650, 16'h0F0F, 8'hC3, 7'd120, 6'd62, 6'd61, 16'h0650, 0);
		add_read(4'd0);
		add_read(4'd1);
		add_read(4'd6);
		add_read(4'd9);
		add_read(4'd10);
		add_read(4'd15);

		// random: a rising window of points keeps landings spread over the table
		for (int k = 0; k < N_RANDOM; k++) begin
			if ($urandom_range(0, 99) < 35) begin
				if ($urandom_range(0, 4) == 0)
					add_read(4'($urandom_range(10, 15)));
				else
					add_read(4'($urandom_range(0, DEPTH - 1)));
			end else begin
				base = longint'(k) * 2_000_000;
				sel = $urandom_range(0, 99);
				if (sel < 70) begin
					pts = 32'(base + $urandom_range(0, 20_000_000));
					recent[k % 8] = pts;
				end else if (sel < 82)
					pts = recent[$urandom_range(0, 7)];
				else if (sel < 92)
					pts = 32'(base / 4);
				else
					pts = $urandom;
				add_insert(pts, 16'($urandom), 8'($urandom),
					($urandom_range(0, 7) == 0) ? 7'($urandom_range(100, 127))
						: 7'($urandom_range(0, 99)),
					($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
						: 6'($urandom_range(0, 59)),
					($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
						: 6'($urandom_range(0, 59)),
					16'($urandom), (k == 0) || (k == N_RANDOM / 2));
			end
			// full drain before these, whatever their kind
			if ((k == 0) || (k == N_RANDOM / 2))
				cmd_backlog[cmd_backlog.size() - 1].drain_first = 1;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || have_cur)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 6) @(posedge clk);

		$display("covered %0d inserts landed (positions seen %b), %0d refused, %0d reads",
			n_landed, landed_at, n_refused, n_reads);
		if (mismatch_count == 0)
			$display("tb_top_k_sorted_insert_table: clean");
		else
			$display("tb_top_k_sorted_insert_table: errors");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("tb_top_k_sorted_insert_table: errors");
		$finish;
	end

endmodule
